>>> rtl/adcrr_pkg.sv
// Package for the ADC round-robin one-shot sequencer.
// Holds shared constants, codes, types and the conversion time function; depends on nothing.

package adcrr_pkg;

  // Number of scanned channels by default (legal range 2 to 4).
  localparam int unsigned NUM_CHANNELS = 4;

  // Field widths.
  localparam int unsigned ChW    = 2;
  localparam int unsigned MaskW  = 4;
  localparam int unsigned VrefW  = 22;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned RawW   = 18;
  localparam int unsigned UvW    = 24;
  localparam int unsigned CfgIdxW = 2;

  // Reset value of the reference voltage in microvolts.
  localparam logic [VrefW-1:0] VREF_RESET_UV = 22'd2048000;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_CH_MASK = 2'd0,
    REG_RES     = 2'd1,
    REG_GAIN    = 2'd2,
    REG_VREF    = 2'd3
  } adcrr_reg_e;

  // Conversion resolution codes.
  typedef enum logic [1:0] {
    RES_12BIT = 2'd0,
    RES_14BIT = 2'd1,
    RES_16BIT = 2'd2,
    RES_18BIT = 2'd3
  } adcrr_res_e;

  // Kinds of result item.
  typedef enum logic [1:0] {
    EV_START  = 2'd0,
    EV_SAMPLE = 2'd1,
    EV_FAIL   = 2'd2
  } adcrr_event_e;

  // Conversion time in milliseconds for each resolution.
  function automatic logic [8:0] conv_time_ms(adcrr_res_e res);
    logic [8:0] t;
    case (res)
      RES_12BIT: t = 9'd5;
      RES_14BIT: t = 9'd20;
      RES_16BIT: t = 9'd80;
      RES_18BIT: t = 9'd320;
      default:   t = 9'd320;
    endcase
    return t;
  endfunction

endpackage

>>> rtl/adcrr_if.sv
// Handshake interfaces for the ADC round-robin one-shot sequencer.
// Depends on adcrr_pkg for the event codes.

// Input channel: one update tick per item.
interface adcrr_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic        read_ok;
  logic [7:0]  rx_byte0;
  logic [7:0]  rx_byte1;
  logic [7:0]  rx_byte2;
  logic [7:0]  rx_byte3;

  modport source (output valid, now_ms, read_ok, rx_byte0, rx_byte1, rx_byte2, rx_byte3,
                  input ready);
  modport sink   (input valid, now_ms, read_ok, rx_byte0, rx_byte1, rx_byte2, rx_byte3,
                  output ready);
endinterface

// Result channel: one event per item.
interface adcrr_out_if;
  logic                        valid;
  logic                        ready;
  adcrr_pkg::adcrr_event_e     event_kind;
  logic [7:0]                  start_byte;
  logic [1:0]                  channel;
  logic signed [17:0]          raw_code;
  logic signed [23:0]          microvolts;

  modport source (output valid, event_kind, start_byte, channel, raw_code, microvolts,
                  input ready);
  modport sink   (input valid, event_kind, start_byte, channel, raw_code, microvolts,
                  output ready);
endinterface

// Configuration write channel.
interface adcrr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [21:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/adc_round_robin_oneshot_sequencer.sv
// Top level of the ADC round-robin one-shot sequencer.
// Depends on adcrr_pkg and the interfaces in adcrr_if.sv.

// The sequencer takes one update tick per clock cycle while events are taken and gives at
// most one event per tick. A tick is captured in an input register; the channel pick, the
// status decode, the 18 x 23 bit scaling multiply and the floor shift then run in one pass
// from that register, and the event lands in the output register once that register is free.
// The input register and the output register let a new tick be taken while an event still
// waits on the output; the state update for a tick completes before the next tick is
// evaluated, so the sustained rate is one tick per cycle as long as events are taken.
// Configuration writes are accepted in any cycle and should be made while no tick is in flight.

module adc_round_robin_oneshot_sequencer #(
  parameter int unsigned NUM_CHANNELS = adcrr_pkg::NUM_CHANNELS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  adcrr_in_if.sink      in_i,
  adcrr_cfg_if.sink     cfg_i,
  adcrr_out_if.source   out_o
);

  localparam logic [2:0] NumCh = 3'(NUM_CHANNELS);

  // Configuration registers.
  logic [3:0]             ch_mask_q;
  adcrr_pkg::adcrr_res_e  res_q;
  logic [1:0]             gain_q;
  logic [21:0]            vref_q;

  // Sequencer state.
  logic [1:0]  cur_ch_q, cur_ch_d;
  logic        running_q, running_d;
  logic [31:0] start_ms_q, start_ms_d;

  // Input register.
  logic        s1_valid_q;
  logic [31:0] s1_now_q;
  logic        s1_ok_q;
  logic [7:0]  s1_b0_q, s1_b1_q, s1_b2_q, s1_b3_q;

  // Output register.
  logic                     out_valid_q;
  adcrr_pkg::adcrr_event_e  ev_q, ev_d;
  logic [7:0]               start_byte_q, start_byte_d;
  logic [1:0]               ch_q, ch_d;
  logic signed [17:0]       raw_q, raw_d;
  logic signed [23:0]       uv_q, uv_d;
  logic                     emit_d;

  logic s1_fire;
  logic in_fire;

  // Configuration is always accepted.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_mask_q <= '0;
      res_q     <= adcrr_pkg::RES_12BIT;
      gain_q    <= '0;
      vref_q    <= adcrr_pkg::VREF_RESET_UV;
    end else if (cfg_i.valid) begin
      case (adcrr_pkg::adcrr_reg_e'(cfg_i.index))
        adcrr_pkg::REG_CH_MASK: ch_mask_q <= cfg_i.data[3:0];
        adcrr_pkg::REG_RES:     res_q     <= adcrr_pkg::adcrr_res_e'(cfg_i.data[1:0]);
        adcrr_pkg::REG_GAIN:    gain_q    <= cfg_i.data[1:0];
        adcrr_pkg::REG_VREF:    vref_q    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Handshake: the evaluated tick leaves the input register once the output register is free.
  assign s1_fire    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_fire;
  assign in_fire    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_now_q <= in_i.now_ms;
      s1_ok_q  <= in_i.read_ok;
      s1_b0_q  <= in_i.rx_byte0;
      s1_b1_q  <= in_i.rx_byte1;
      s1_b2_q  <= in_i.rx_byte2;
      s1_b3_q  <= in_i.rx_byte3;
    end
  end

  // Conversion wait check on the wrapped elapsed time.
  logic [31:0] elapsed;
  logic        waiting;
  assign elapsed = s1_now_q - start_ms_q;
  assign waiting = running_q && (elapsed < 32'(adcrr_pkg::conv_time_ms(res_q)));

  // Round-robin pick: first enabled channel at or after the current one.
  logic [1:0] pick_ch;
  logic       pick_found;
  always_comb begin
    logic [2:0] cand;
    pick_ch    = cur_ch_q;
    pick_found = 1'b0;
    for (int k = NUM_CHANNELS - 1; k >= 0; k--) begin
      cand = {1'b0, cur_ch_q} + 3'(k);
      if (cand >= NumCh) begin
        cand = cand - NumCh;
      end
      if (ch_mask_q[cand[1:0]]) begin
        pick_ch    = cand[1:0];
        pick_found = 1'b1;
      end
    end
  end

  logic [1:0] next_ch;
  assign next_ch = ({1'b0, pick_ch} == NumCh - 3'd1) ? 2'd0 : pick_ch + 2'd1;

  // Data decode: sign-extended code at the set resolution.
  logic signed [23:0] v24;
  logic signed [15:0] v16;
  logic signed [17:0] raw_code;
  logic [4:0]         shamt;
  logic [7:0]         status;
  assign v24    = {s1_b0_q, s1_b1_q, s1_b2_q};
  assign v16    = {s1_b0_q, s1_b1_q};
  assign status = (res_q == adcrr_pkg::RES_18BIT) ? s1_b3_q : s1_b2_q;

  always_comb begin
    case (res_q)
      adcrr_pkg::RES_12BIT: begin
        raw_code = 18'(v16 >>> 4);
        shamt    = 5'd10;
      end
      adcrr_pkg::RES_14BIT: begin
        raw_code = 18'(v16 >>> 2);
        shamt    = 5'd12;
      end
      adcrr_pkg::RES_16BIT: begin
        raw_code = 18'(v16);
        shamt    = 5'd14;
      end
      adcrr_pkg::RES_18BIT: begin
        raw_code = 18'(v24 >>> 6);
        shamt    = 5'd16;
      end
      default: begin
        raw_code = 18'(v16);
        shamt    = 5'd14;
      end
    endcase
  end

  // Scaling: raw * 2 * vref floored by 2^(gain + N - 1), the factor of two folded into the shift.
  logic signed [40:0] prod;
  logic signed [40:0] scaled;
  logic [4:0]         total_shift;
  assign prod        = raw_code * $signed({1'b0, vref_q});
  assign total_shift = shamt + {3'd0, gain_q};
  assign scaled      = prod >>> total_shift;

  // Event selection and state update for the evaluated tick.
  always_comb begin
    cur_ch_d     = cur_ch_q;
    running_d    = running_q;
    start_ms_d   = start_ms_q;
    emit_d       = 1'b0;
    ev_d         = adcrr_pkg::EV_START;
    start_byte_d = '0;
    ch_d         = pick_ch;
    raw_d        = '0;
    uv_d         = '0;
    if (!waiting && pick_found) begin
      cur_ch_d = pick_ch;
      if (!running_q) begin
        emit_d       = 1'b1;
        start_byte_d = {1'b1, pick_ch, 1'b0, res_q, gain_q};
        running_d    = 1'b1;
        start_ms_d   = s1_now_q;
      end else if (!s1_ok_q) begin
        emit_d    = 1'b1;
        ev_d      = adcrr_pkg::EV_FAIL;
        running_d = 1'b0;
      end else if (!status[7]) begin
        emit_d    = 1'b1;
        ev_d      = adcrr_pkg::EV_SAMPLE;
        raw_d     = raw_code;
        uv_d      = scaled[23:0];
        cur_ch_d  = next_ch;
        running_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_ch_q    <= '0;
      running_q   <= 1'b0;
      start_ms_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_fire) begin
        cur_ch_q   <= cur_ch_d;
        running_q  <= running_d;
        start_ms_q <= start_ms_d;
      end
      if (s1_fire) begin
        out_valid_q <= emit_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (s1_fire && emit_d) begin
      ev_q         <= ev_d;
      start_byte_q <= start_byte_d;
      ch_q         <= ch_d;
      raw_q        <= raw_d;
      uv_q         <= uv_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.event_kind = ev_q;
  assign out_o.start_byte = start_byte_q;
  assign out_o.channel    = ch_q;
  assign out_o.raw_code   = raw_q;
  assign out_o.microvolts = uv_q;

endmodule

>>> tb/sv/adc_round_robin_oneshot_sequencer_tb.sv
// Testbench for the ADC round-robin one-shot sequencer: directed and random update ticks
// under several register settings, each event checked against a built-in scan predictor.
// Depends on adcrr_pkg, the interfaces in adcrr_if.sv and the sequencer top level.
`timescale 1ns / 1ps

module adc_round_robin_oneshot_sequencer_tb;

  localparam int unsigned NUM_CH = adcrr_pkg::NUM_CHANNELS;

  // One update tick as it is driven onto the input channel.
  typedef struct packed {
    logic [31:0] now_ms;
    logic        read_ok;
    logic [7:0]  rx_byte0;
    logic [7:0]  rx_byte1;
    logic [7:0]  rx_byte2;
    logic [7:0]  rx_byte3;
  } tick_t;

  // One event as the sequencer should emit it.
  typedef struct {
    adcrr_pkg::adcrr_event_e kind;
    logic [7:0]              start_byte;
    logic [1:0]              channel;
    logic signed [17:0]      raw_code;
    logic signed [23:0]      microvolts;
  } scan_event_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  adcrr_in_if  in_if ();
  adcrr_cfg_if cfg_if ();
  adcrr_out_if out_if ();

  adc_round_robin_oneshot_sequencer uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  // Register shadows and scan state of the predictor.
  logic [3:0]            cfg_mask = 4'h0;
  adcrr_pkg::adcrr_res_e cfg_res  = adcrr_pkg::RES_12BIT;
  logic [1:0]            cfg_gain = 2'd0;
  logic [21:0]           cfg_vref = adcrr_pkg::VREF_RESET_UV;
  int unsigned scan_ch = 0;
  bit          conv_running = 1'b0;
  logic [31:0] conv_start_ms = '0;

  tick_t       tick_queue[$];
  scan_event_t event_queue[$];
  tick_t       tx_tick;
  bit          tx_busy = 1'b0;
  logic [31:0] scan_ms = '0;

  int idle_pct_tx = 0;
  int idle_pct_rx = 0;
  int ticks_sent = 0;
  int settings_used = 0;
  int starts_seen = 0;
  int samples_seen = 0;
  int faults_seen = 0;
  int mismatches = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Conversion time in milliseconds for a resolution.
  function automatic int unsigned conv_ms(adcrr_pkg::adcrr_res_e res);
    case (res)
      adcrr_pkg::RES_12BIT: return 5;
      adcrr_pkg::RES_14BIT: return 20;
      adcrr_pkg::RES_16BIT: return 80;
      default:              return 320;
    endcase
  endfunction

  // Advance the scan state by one accepted tick and queue the event it causes, if any.
  function automatic void predict_scan_event(tick_t t);
    scan_event_t        ev;
    logic [31:0]        elapsed;
    int unsigned        ch;
    int unsigned        pick;
    bit                 found;
    logic [7:0]         status;
    logic signed [23:0] code24;
    logic signed [15:0] code16;
    int unsigned        nbits;
    longint             prod;

    elapsed = t.now_ms - conv_start_ms;
    if (conv_running && elapsed < conv_ms(cfg_res)) return;

    // Round-robin pick from the current channel, also while a conversion runs.
    found = 1'b0;
    ch = 0;
    for (int k = 0; k < NUM_CH; k++) begin
      pick = (scan_ch + k) % NUM_CH;
      if (!found && cfg_mask[pick]) begin
        found = 1'b1;
        ch = pick;
      end
    end
    if (!found) return;
    scan_ch = ch;

    ev.kind = adcrr_pkg::EV_START;
    ev.start_byte = '0;
    ev.channel = 2'(ch);
    ev.raw_code = '0;
    ev.microvolts = '0;

    if (!conv_running) begin
      ev.start_byte = {1'b1, 2'(ch), 1'b0, cfg_res, cfg_gain};
      conv_running = 1'b1;
      conv_start_ms = t.now_ms;
      event_queue.push_back(ev);
      return;
    end

    if (!t.read_ok) begin
      ev.kind = adcrr_pkg::EV_FAIL;
      conv_running = 1'b0;
      event_queue.push_back(ev);
      return;
    end

    status = (cfg_res == adcrr_pkg::RES_18BIT) ? t.rx_byte3 : t.rx_byte2;
    if (status[7]) return;

    // Arithmetic shifts give the floor of the division by a power of two.
    if (cfg_res == adcrr_pkg::RES_18BIT) begin
      code24 = {t.rx_byte0, t.rx_byte1, t.rx_byte2};
      ev.raw_code = code24 >>> 6;
      nbits = 18;
    end else begin
      code16 = {t.rx_byte0, t.rx_byte1};
      case (cfg_res)
        adcrr_pkg::RES_12BIT: begin
          ev.raw_code = code16 >>> 4;
          nbits = 12;
        end
        adcrr_pkg::RES_14BIT: begin
          ev.raw_code = code16 >>> 2;
          nbits = 14;
        end
        default: begin
          ev.raw_code = code16;
          nbits = 16;
        end
      endcase
    end
    prod = longint'(ev.raw_code) * 2 * longint'(cfg_vref);
    ev.microvolts = prod >>> (cfg_gain + nbits - 1);
    ev.kind = adcrr_pkg::EV_SAMPLE;
    scan_ch = (ch + 1) % NUM_CH;
    conv_running = 1'b0;
    event_queue.push_back(ev);
  endfunction

  function automatic void push_tick(logic [31:0] now, logic ok, logic [7:0] b0,
                                    logic [7:0] b1, logic [7:0] b2, logic [7:0] b3);
    tick_t t;
    t.now_ms = now;
    t.read_ok = ok;
    t.rx_byte0 = b0;
    t.rx_byte1 = b1;
    t.rx_byte2 = b2;
    t.rx_byte3 = b3;
    tick_queue.push_back(t);
  endfunction

  // Random tick on a running time base: mostly short steps that keep a conversion waiting,
  // steps just past the conversion time, and now and then a jump anywhere in time.
  function automatic void push_random_tick();
    int unsigned ct;
    int unsigned pick;
    logic [7:0]  status;
    logic [7:0]  other;
    ct = conv_ms(cfg_res);
    pick = $urandom_range(99, 0);
    if (pick < 50) scan_ms = scan_ms + $urandom_range(ct / 2, 0);
    else if (pick < 60) scan_ms = scan_ms + ct - 1;
    else if (pick < 92) scan_ms = scan_ms + ct + $urandom_range(3, 0);
    else scan_ms = $urandom();
    status = 8'($urandom_range(255, 0));
    status[7] = ($urandom_range(99, 0) < 20);
    other = 8'($urandom_range(255, 0));
    if (cfg_res == adcrr_pkg::RES_18BIT)
      push_tick(scan_ms, $urandom_range(99, 0) >= 8, 8'($urandom_range(255, 0)),
                8'($urandom_range(255, 0)), other, status);
    else
      push_tick(scan_ms, $urandom_range(99, 0) >= 8, 8'($urandom_range(255, 0)),
                8'($urandom_range(255, 0)), status, other);
  endfunction

  // Register write over the configuration channel; the shadow follows on acceptance.
  task automatic write_reg(adcrr_pkg::adcrr_reg_e idx, logic [21:0] value);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      adcrr_pkg::REG_CH_MASK: cfg_mask = value[3:0];
      adcrr_pkg::REG_RES:     cfg_res  = adcrr_pkg::adcrr_res_e'(value[1:0]);
      adcrr_pkg::REG_GAIN:    cfg_gain = value[1:0];
      adcrr_pkg::REG_VREF:    cfg_vref = value;
      default:                ;
    endcase
  endtask

  task automatic apply_settings(logic [3:0] mask, adcrr_pkg::adcrr_res_e res,
                                logic [1:0] gain, logic [21:0] vref);
    write_reg(adcrr_pkg::REG_CH_MASK, 22'(mask));
    write_reg(adcrr_pkg::REG_RES, 22'(res));
    write_reg(adcrr_pkg::REG_GAIN, 22'(gain));
    write_reg(adcrr_pkg::REG_VREF, vref);
    settings_used++;
  endtask

  // Wait until every queued tick is taken and every event is back, then let the pipeline
  // settle so that ticks without an event are surely out of the block.
  task automatic drain_ticks();
    while (tick_queue.size() != 0 || tx_busy || event_queue.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    while (event_queue.size() != 0) @(posedge clk_i);
  endtask

  // Driver: presents queued ticks, idling at random, and predicts each accepted one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_scan_event(tx_tick);
        ticks_sent++;
        tx_busy = 1'b0;
      end
      if (!in_if.valid || in_if.ready) begin
        if (tick_queue.size() != 0 && $urandom_range(99, 0) >= idle_pct_tx) begin
          tx_tick = tick_queue.pop_front();
          tx_busy = 1'b1;
          in_if.valid    <= 1'b1;
          in_if.now_ms   <= tx_tick.now_ms;
          in_if.read_ok  <= tx_tick.read_ok;
          in_if.rx_byte0 <= tx_tick.rx_byte0;
          in_if.rx_byte1 <= tx_tick.rx_byte1;
          in_if.rx_byte2 <= tx_tick.rx_byte2;
          in_if.rx_byte3 <= tx_tick.rx_byte3;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stalls the result channel at random and checks each accepted event in order.
  always @(posedge clk_i or negedge rst_ni) begin : event_check
    scan_event_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (event_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: event %s on channel %0d with nothing pending", $realtime,
                     out_if.event_kind.name(), out_if.channel);
        end else begin
          want = event_queue.pop_front();
          case (want.kind)
            adcrr_pkg::EV_START:  starts_seen++;
            adcrr_pkg::EV_SAMPLE: samples_seen++;
            default:              faults_seen++;
          endcase
          if (out_if.event_kind !== want.kind || out_if.start_byte !== want.start_byte ||
              out_if.channel !== want.channel || out_if.raw_code !== want.raw_code ||
              out_if.microvolts !== want.microvolts) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: expected %s byte %h ch %0d raw %0d uv %0d,",
                       $realtime, want.kind.name(), want.start_byte, want.channel,
                       want.raw_code, want.microvolts,
                       " got %s byte %h ch %0d raw %0d uv %0d",
                       out_if.event_kind.name(), out_if.start_byte, out_if.channel,
                       out_if.raw_code, out_if.microvolts);
          end
        end
      end
      out_if.ready <= ($urandom_range(99, 0) >= idle_pct_rx);
    end
  end

  // Stimulus and phase sequencing.
  initial begin
    logic [3:0]            mask;
    adcrr_pkg::adcrr_res_e res;
    logic [1:0]            gain;
    logic [21:0]           vref;
    int                    count;

    in_if.valid = 1'b0;
    in_if.now_ms = '0;
    in_if.read_ok = 1'b0;
    in_if.rx_byte0 = '0;
    in_if.rx_byte1 = '0;
    in_if.rx_byte2 = '0;
    in_if.rx_byte3 = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = adcrr_pkg::REG_CH_MASK;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    idle_pct_tx = 28;
    idle_pct_rx = 52;

    // No channel enabled after reset: ticks pass without an event.
    push_tick(32'd0, 1'b1, 8'h12, 8'h34, 8'h00, 8'h00);
    push_tick(32'd400, 1'b1, 8'h12, 8'h34, 8'h00, 8'h00);
    drain_ticks();

    // 12-bit: wait, not-ready status, failed read and restart, code extremes, time wrap.
    apply_settings(4'hF, adcrr_pkg::RES_12BIT, 2'd0, 22'd4096000);
    push_tick(32'd0, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
    push_tick(32'd3, 1'b1, 8'h7F, 8'hFF, 8'h00, 8'h00);
    push_tick(32'd5, 1'b1, 8'h7F, 8'hFF, 8'h80, 8'h00);
    push_tick(32'd6, 1'b0, 8'h7F, 8'hFF, 8'h00, 8'h00);
    push_tick(32'd7, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
    push_tick(32'd12, 1'b1, 8'h7F, 8'hFF, 8'h00, 8'hFF);
    push_tick(32'd13, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
    push_tick(32'd20, 1'b1, 8'h80, 8'h00, 8'h7F, 8'h80);
    push_tick(32'hFFFF_FFFE, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
    push_tick(32'h0000_0002, 1'b1, 8'hFF, 8'hFF, 8'h7F, 8'hFF);
    push_tick(32'h0000_0003, 1'b1, 8'hFF, 8'hFF, 8'h7F, 8'hFF);
    push_tick(32'hFFFF_FFFF, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
    push_tick(32'h0000_0004, 1'b1, 8'h00, 8'h00, 8'h00, 8'h80);
    drain_ticks();

    // 18-bit with channels skipped: status in the fourth byte, code extremes, failed read.
    apply_settings(4'hA, adcrr_pkg::RES_18BIT, 2'd3, 22'd4096000);
    push_tick(32'd100, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
    push_tick(32'd419, 1'b1, 8'h7F, 8'hFF, 8'hFF, 8'h00);
    push_tick(32'd420, 1'b1, 8'h7F, 8'hFF, 8'hFF, 8'h00);
    push_tick(32'd421, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
    push_tick(32'd741, 1'b1, 8'h80, 8'h00, 8'h00, 8'h80);
    push_tick(32'd742, 1'b1, 8'h80, 8'h00, 8'h00, 8'h7F);
    push_tick(32'd800, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
    push_tick(32'd1200, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
    drain_ticks();

    // Random phases, each under fresh register settings.
    for (int p = 0; p < 13; p++) begin
      if (p < 4) begin
        idle_pct_tx = 28;
        idle_pct_rx = 52;
      end else if (p < 9) begin
        idle_pct_tx = 52;
        idle_pct_rx = 28;
      end else begin
        idle_pct_tx = 0;
        idle_pct_rx = 0;
      end
      mask = 4'($urandom_range(15, 1));
      res  = adcrr_pkg::adcrr_res_e'(p % 4);
      gain = 2'($urandom_range(3, 0));
      vref = 22'($urandom_range(4096000, 0));
      if (p == 1) begin
        mask = 4'hF;
        gain = 2'd0;
        vref = 22'd4096000;
      end
      if (p == 2) begin
        mask = 4'h1;
        gain = 2'd3;
        vref = 22'd0;
      end
      if (p == 5) begin
        mask = 4'h8;
        gain = 2'd3;
        vref = 22'd4096000;
      end
      if (p == 6) mask = 4'h0;
      apply_settings(mask, res, gain, vref);
      count = (mask == 4'h0) ? 20 : 100;
      repeat (count) push_random_tick();
      drain_ticks();
    end

    repeat (8) @(posedge clk_i);
    $display("Ran %0d ticks over %0d register settings with random idling on both sides.",
             ticks_sent, settings_used);
    $display("Checked %0d start, %0d sample and %0d read fault events.",
             starts_seen, samples_seen, faults_seen);
    if (mismatches == 0 && event_queue.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #2_000_000;
    $display("Timed out with %0d events still pending.", event_queue.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> sim.f
rtl/adcrr_pkg.sv
rtl/adcrr_if.sv
rtl/adc_round_robin_oneshot_sequencer.sv
tb/sv/adc_round_robin_oneshot_sequencer_tb.sv
